// ===== design/mips_integer_execute_unit_assert.svh =====
// Assertion macros for the integer execute unit checker.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MIEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication.
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

// ===== design/mieu_pkg.sv =====
// ============================================================================
// mieu_pkg
// Operation codes, status codes and shared types of the integer execute unit.
// ============================================================================
`timescale 1ns / 1ps
package mieu_pkg;
    localparam int XLEN = 32;
    localparam int OP_W = 6;

    localparam logic [OP_W-1:0] OP_ADD   = 6'd0;
    localparam logic [OP_W-1:0] OP_NOP   = 6'd1;
    localparam logic [OP_W-1:0] OP_ADDU  = 6'd2;
    localparam logic [OP_W-1:0] OP_AND   = 6'd3;
    localparam logic [OP_W-1:0] OP_MFHI  = 6'd4;
    localparam logic [OP_W-1:0] OP_MFLO  = 6'd5;
    localparam logic [OP_W-1:0] OP_OR    = 6'd6;
    localparam logic [OP_W-1:0] OP_SEB   = 6'd7;
    localparam logic [OP_W-1:0] OP_SLTU  = 6'd8;
    localparam logic [OP_W-1:0] OP_SUBU  = 6'd9;
    localparam logic [OP_W-1:0] OP_XOR   = 6'd10;
    localparam logic [OP_W-1:0] OP_BREAK = 6'd11;
    localparam logic [OP_W-1:0] OP_DIV   = 6'd12;
    localparam logic [OP_W-1:0] OP_JALR  = 6'd13;
    localparam logic [OP_W-1:0] OP_JR    = 6'd14;
    localparam logic [OP_W-1:0] OP_MULT  = 6'd15;
    localparam logic [OP_W-1:0] OP_SLL   = 6'd16;
    localparam logic [OP_W-1:0] OP_SRA   = 6'd17;
    localparam logic [OP_W-1:0] OP_SRL   = 6'd18;
    localparam logic [OP_W-1:0] OP_SUB   = 6'd19;
    localparam logic [OP_W-1:0] OP_ADDI  = 6'd20;
    localparam logic [OP_W-1:0] OP_ADDIU = 6'd21;
    localparam logic [OP_W-1:0] OP_ANDI  = 6'd22;
    localparam logic [OP_W-1:0] OP_BEQ   = 6'd23;
    localparam logic [OP_W-1:0] OP_BGTZ  = 6'd24;
    localparam logic [OP_W-1:0] OP_BLEZ  = 6'd25;
    localparam logic [OP_W-1:0] OP_BNE   = 6'd26;
    localparam logic [OP_W-1:0] OP_J     = 6'd27;
    localparam logic [OP_W-1:0] OP_JAL   = 6'd28;
    localparam logic [OP_W-1:0] OP_LUI   = 6'd29;
    localparam logic [OP_W-1:0] OP_ORI   = 6'd30;
    localparam logic [OP_W-1:0] OP_SLTIU = 6'd31;
    localparam logic [OP_W-1:0] OP_BLTZ  = 6'd32;
    localparam logic [OP_W-1:0] OP_BGEZ  = 6'd33;
    localparam logic [OP_W-1:0] OP_SLT   = 6'd34;
    localparam logic [OP_W-1:0] OP_SLTI  = 6'd35;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_BREAK = 2'd3;

    // Multi-cycle unit command and status.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } md_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;
endpackage

// ===== design/mieu_muldiv.sv =====
// ============================================================================
// mieu_muldiv
// Shared shift/add unit: signed multiply and signed divide, one bit a cycle.
// ============================================================================
`timescale 1ns / 1ps
module mieu_muldiv
(
    input  logic              clk,
    input  logic              rst_n,
    input  mieu_pkg::md_cmd_t cmd,
    output mieu_pkg::md_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [31:0] acc_reg, acc_next;     // partial product high / remainder
    logic [31:0] sh_reg, sh_next;       // multiplier / dividend-quotient
    logic [31:0] b_reg, b_next;         // magnitude of operand b
    logic        done_reg, done_next;
    logic [32:0] sum;
    logic [32:0] trial;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    always_comb
    begin
        ma = cmd.a[31] ? (32'd0 - cmd.a) : cmd.a;
        mb = cmd.b[31] ? (32'd0 - cmd.b) : cmd.b;
        sum   = {1'b0, acc_reg} + {1'b0, (sh_reg[0] ? b_reg : 32'd0)};
        trial = {acc_reg, sh_reg[31]} - {1'b0, b_reg};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        div_next = div_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        acc_next = acc_reg;
        sh_next = sh_reg;
        b_next = b_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            div_next = cmd.is_div;
            neg_q_next = cmd.a[31] ^ cmd.b[31];
            neg_r_next = cmd.a[31];
            acc_next = 32'd0;
            sh_next = ma;
            b_next = mb;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[32])
                begin
                    acc_next = trial[31:0];
                    sh_next = {sh_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[30:0], sh_reg[31]};
                    sh_next = {sh_reg[30:0], 1'b0};
                end
            end
            else
            begin
                acc_next = sum[32:1];
                sh_next = {sum[0], sh_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        acc_reg <= acc_next;
        sh_reg <= sh_next;
        b_reg <= b_next;
    end

    always_comb
    begin
        prod = {acc_reg, sh_reg};
        rsp.done = done_reg;
        if (div_reg)
        begin
            rsp.lo = neg_q_reg ? (32'd0 - sh_reg) : sh_reg;
            rsp.hi = neg_r_reg ? (32'd0 - acc_reg) : acc_reg;
        end
        else
        begin
            prod = neg_q_reg ? (64'd0 - prod) : prod;
            rsp.hi = prod[63:32];
            rsp.lo = prod[31:0];
        end
    end
endmodule

// ===== design/mieu_alu.sv =====
// ============================================================================
// mieu_alu
// Combinational ALU, branch and jump resolution.
// ============================================================================
`timescale 1ns / 1ps
module mieu_alu
(
    input  logic [5:0]  op,
    input  logic [31:0] rs,
    input  logic [31:0] rt,
    input  logic [4:0]  sh,
    input  logic [15:0] imm,
    input  logic [15:0] off,
    input  logic [25:0] tgt,
    input  logic [31:0] pc,
    input  logic [31:0] hi,
    input  logic [31:0] lo,
    output logic [31:0] res,
    output logic        wr,
    output logic [31:0] npc,
    output logic        taken,
    output logic [1:0]  st
);
    logic [31:0] seq, link, bt, jt, simm, bsel, s, d;
    logic        cond;

    always_comb
    begin
        seq  = pc + 32'd4;
        link = pc + 32'd8;
        simm = {{16{imm[15]}}, imm};
        bt   = seq + {{14{off[15]}}, off, 2'b00};
        jt   = {seq[31:28], tgt, 2'b00};
        bsel = (op == mieu_pkg::OP_ADDI) ? simm : rt;
        s    = rs + bsel;
        d    = rs - rt;
        res = 32'd0;
        wr = 1'b0;
        npc = seq;
        taken = 1'b0;
        st = mieu_pkg::ST_OK;
        cond = 1'b0;
        case (op)
            mieu_pkg::OP_ADD, mieu_pkg::OP_ADDI:
            begin
                if ((~(rs[31] ^ bsel[31])) & (rs[31] ^ s[31])) st = mieu_pkg::ST_OVF;
                else
                begin
                    res = s;
                    wr = 1'b1;
                end
            end
            mieu_pkg::OP_SUB:
            begin
                if ((rs[31] ^ rt[31]) & (rs[31] ^ d[31])) st = mieu_pkg::ST_OVF;
                else
                begin
                    res = d;
                    wr = 1'b1;
                end
            end
            mieu_pkg::OP_ADDU:  begin res = rs + rt; wr = 1'b1; end
            mieu_pkg::OP_ADDIU: begin res = rs + simm; wr = 1'b1; end
            mieu_pkg::OP_SUBU:  begin res = d; wr = 1'b1; end
            mieu_pkg::OP_AND:   begin res = rs & rt; wr = 1'b1; end
            mieu_pkg::OP_OR:    begin res = rs | rt; wr = 1'b1; end
            mieu_pkg::OP_XOR:   begin res = rs ^ rt; wr = 1'b1; end
            mieu_pkg::OP_ANDI:  begin res = rs & {16'd0, imm}; wr = 1'b1; end
            mieu_pkg::OP_ORI:   begin res = rs | {16'd0, imm}; wr = 1'b1; end
            mieu_pkg::OP_LUI:   begin res = {imm, 16'd0}; wr = 1'b1; end
            mieu_pkg::OP_SEB:   begin res = {{24{rt[7]}}, rt[7:0]}; wr = 1'b1; end
            mieu_pkg::OP_SLT:   begin res = {31'd0, $signed(rs) < $signed(rt)}; wr = 1'b1; end
            mieu_pkg::OP_SLTI:  begin res = {31'd0, $signed(rs) < $signed(simm)}; wr = 1'b1; end
            mieu_pkg::OP_SLTU:  begin res = {31'd0, rs < rt}; wr = 1'b1; end
            mieu_pkg::OP_SLTIU: begin res = {31'd0, rs < simm}; wr = 1'b1; end
            mieu_pkg::OP_SLL:   begin res = rt << sh; wr = 1'b1; end
            mieu_pkg::OP_SRL:   begin res = rt >> sh; wr = 1'b1; end
            mieu_pkg::OP_SRA:   begin res = $unsigned($signed(rt) >>> sh); wr = 1'b1; end
            mieu_pkg::OP_MFHI:  begin res = hi; wr = 1'b1; end
            mieu_pkg::OP_MFLO:  begin res = lo; wr = 1'b1; end
            mieu_pkg::OP_DIV:   if (rt == 32'd0) st = mieu_pkg::ST_DIV0;
            mieu_pkg::OP_BREAK: st = mieu_pkg::ST_BREAK;
            mieu_pkg::OP_JR:    begin npc = rs; taken = 1'b1; end
            mieu_pkg::OP_JALR:  begin res = link; wr = 1'b1; npc = rs; taken = 1'b1; end
            mieu_pkg::OP_J:     begin npc = jt; taken = 1'b1; end
            mieu_pkg::OP_JAL:   begin res = link; wr = 1'b1; npc = jt; taken = 1'b1; end
            mieu_pkg::OP_BEQ:   cond = (rs == rt);
            mieu_pkg::OP_BNE:   cond = (rs != rt);
            mieu_pkg::OP_BGTZ:  cond = !rs[31] && (rs != 32'd0);
            mieu_pkg::OP_BLEZ:  cond = rs[31] || (rs == 32'd0);
            mieu_pkg::OP_BLTZ:  cond = rs[31];
            mieu_pkg::OP_BGEZ:  cond = !rs[31];
            default: ;
        endcase
        if (cond)
        begin
            npc = bt;
            taken = 1'b1;
        end
    end
endmodule

// ===== design/mips_integer_execute_unit.sv =====
// ============================================================================
// mips_integer_execute_unit
// MIPS32 integer execute stage with HI/LO and a shared multiply/divide unit.
// ============================================================================
// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tdata: req_type..pc_value (168 bits)
// m_axis   out  m_axis_tvalid/tready    tdata: result..status (72 bits)
//
// ALU ops: the result goes straight into the result register on accept.
// MULT / DIV (nonzero divisor): held in S_MD until the 1-bit-per-cycle
//   shift/add loop in mieu_muldiv signals done.
// One item at a time; s_axis_tready is low while busy or while a result waits.
// A held result is kept until m_axis_tready; reset clears HI, LO and control.
// ============================================================================
`timescale 1ns / 1ps
module mips_integer_execute_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[5:0], rs_value[37:6], rt_value[69:38], shift_amount[74:70],
    // immediate[90:75], branch_offset[106:91], jump_target[132:107],
    // pc_value[164:133], zero pad
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[31:0], writes_register[32], next_pc[64:33],
    // branch_taken[65], status[67:66], zero pad
    output logic [71:0]  m_axis_tdata
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] hi_reg, lo_reg;
    logic [67:0] out_reg, out_next;
    logic        accept;
    logic [5:0]  op;
    logic [31:0] res, npc;
    logic        wr, taken, is_md;
    logic [1:0]  st;
    mieu_pkg::md_cmd_t cmd;
    mieu_pkg::md_rsp_t rsp;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, out_reg};
    assign accept = s_axis_tvalid && s_axis_tready;
    assign op = s_axis_tdata[5:0];

    mieu_alu u_alu
    (
        .op(op), .rs(s_axis_tdata[37:6]), .rt(s_axis_tdata[69:38]),
        .sh(s_axis_tdata[74:70]), .imm(s_axis_tdata[90:75]),
        .off(s_axis_tdata[106:91]), .tgt(s_axis_tdata[132:107]),
        .pc(s_axis_tdata[164:133]), .hi(hi_reg), .lo(lo_reg),
        .res(res), .wr(wr), .npc(npc), .taken(taken), .st(st)
    );

    // MULT always, DIV only with a nonzero divisor, go to the shared unit.
    assign is_md = (op == mieu_pkg::OP_MULT) ||
                   ((op == mieu_pkg::OP_DIV) && (s_axis_tdata[69:38] != 32'd0));
    assign cmd.start  = accept && is_md;
    assign cmd.is_div = (op == mieu_pkg::OP_DIV);
    assign cmd.a      = s_axis_tdata[37:6];
    assign cmd.b      = s_axis_tdata[69:38];

    mieu_muldiv u_md (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));

    always_comb
    begin
        state_next = state_reg;
        out_next = out_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    out_next = {st, taken, npc, wr, res};
                    state_next = is_md ? S_MD : S_OUT;
                end
            S_MD:
                if (rsp.done) state_next = S_OUT;
            S_OUT:
                if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hi_reg <= 32'd0;
            lo_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_MD) && rsp.done)
            begin
                hi_reg <= rsp.hi;
                lo_reg <= rsp.lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule

// ===== design/mieu_checker.sv =====
// ============================================================================
// mieu_checker
// Port-level checks of the integer execute unit.
// ============================================================================
`timescale 1ns / 1ps
`include "mips_integer_execute_unit_assert.svh"
module mieu_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [167:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);
    `MIEU_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `MIEU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `MIEU_ASSERT_NEXT(a_accept_blocks, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready)
    `MIEU_ASSERT_IMPL(a_no_write_on_fault, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[67:66] != mieu_pkg::ST_OK), !m_axis_tdata[32])
    `MIEU_ASSERT_IMPL(a_zero_when_no_write, clk, rst_n,
        m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0)
endmodule

bind mips_integer_execute_unit mieu_checker u_mieu_checker
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== verif/mips_integer_execute_unit_tb.sv =====
// ============================================================================
// mips_integer_execute_unit_tb
// Self-checking bench: directed corner items, then random instruction mixes
// under varying source and sink throttling, compared against a local model.
// ============================================================================
`timescale 1ns / 1ps
module mips_integer_execute_unit_tb;

    // Field order matches the result bus, status in the top bits.
    typedef struct packed {
        logic [1:0]  status;
        logic        branch_taken;
        logic [31:0] next_pc;
        logic        writes_register;
        logic [31:0] result_value;
    } exec_result_t;

    // Execute model with its own HI/LO copy; queue of pending results.
    class exec_scoreboard;
        logic [31:0]  hi_q;
        logic [31:0]  lo_q;
        exec_result_t pending[$];
        int           errors;
        int           checked;

        function new();
            hi_q = '0;
            lo_q = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void note_instr(logic [167:0] d);
            logic [5:0]  op;
            logic [31:0] rs, rt, simm, off, seq, s, ma, mb, q, r;
            logic [4:0]  sh;
            logic [15:0] imm;
            logic [63:0] p;
            logic        cond;
            exec_result_t e;
            op   = d[5:0];
            rs   = d[37:6];
            rt   = d[69:38];
            sh   = d[74:70];
            imm  = d[90:75];
            off  = {{16{d[106]}}, d[106:91]};
            seq  = d[164:133] + 32'd4;
            simm = {{16{imm[15]}}, imm};
            cond = 1'b0;
            e = '0;
            e.next_pc = seq;
            case (op)
                mieu_pkg::OP_ADD, mieu_pkg::OP_ADDI:
                begin
                    q = (op == mieu_pkg::OP_ADD) ? rt : simm;
                    s = rs + q;
                    if (~(rs[31] ^ q[31]) & (rs[31] ^ s[31])) e.status = mieu_pkg::ST_OVF;
                    else begin e.result_value = s; e.writes_register = 1; end
                end
                mieu_pkg::OP_SUB:
                begin
                    s = rs - rt;
                    if ((rs[31] ^ rt[31]) & (rs[31] ^ s[31])) e.status = mieu_pkg::ST_OVF;
                    else begin e.result_value = s; e.writes_register = 1; end
                end
                mieu_pkg::OP_ADDU:  e.result_value = rs + rt;
                mieu_pkg::OP_ADDIU: e.result_value = rs + simm;
                mieu_pkg::OP_SUBU:  e.result_value = rs - rt;
                mieu_pkg::OP_AND:   e.result_value = rs & rt;
                mieu_pkg::OP_OR:    e.result_value = rs | rt;
                mieu_pkg::OP_XOR:   e.result_value = rs ^ rt;
                mieu_pkg::OP_ANDI:  e.result_value = rs & {16'd0, imm};
                mieu_pkg::OP_ORI:   e.result_value = rs | {16'd0, imm};
                mieu_pkg::OP_LUI:   e.result_value = {imm, 16'd0};
                mieu_pkg::OP_SEB:   e.result_value = {{24{rt[7]}}, rt[7:0]};
                mieu_pkg::OP_SLT:   e.result_value = ($signed(rs) < $signed(rt)) ? 1 : 0;
                mieu_pkg::OP_SLTI:  e.result_value = ($signed(rs) < $signed(simm)) ? 1 : 0;
                mieu_pkg::OP_SLTU:  e.result_value = (rs < rt) ? 1 : 0;
                mieu_pkg::OP_SLTIU: e.result_value = (rs < simm) ? 1 : 0;
                mieu_pkg::OP_SLL:   e.result_value = rt << sh;
                mieu_pkg::OP_SRL:   e.result_value = rt >> sh;
                mieu_pkg::OP_SRA:   e.result_value = $signed(rt) >>> sh;
                mieu_pkg::OP_MFHI:  e.result_value = hi_q;
                mieu_pkg::OP_MFLO:  e.result_value = lo_q;
                mieu_pkg::OP_MULT:
                begin
                    p = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
                    hi_q = p[63:32];
                    lo_q = p[31:0];
                end
                mieu_pkg::OP_DIV:
                begin
                    if (rt == 0) e.status = mieu_pkg::ST_DIV0;
                    else
                    begin
                        ma = rs[31] ? -rs : rs;
                        mb = rt[31] ? -rt : rt;
                        q = ma / mb;
                        r = ma % mb;
                        lo_q = (rs[31] != rt[31]) ? -q : q;
                        hi_q = rs[31] ? -r : r;
                    end
                end
                mieu_pkg::OP_BREAK: e.status = mieu_pkg::ST_BREAK;
                mieu_pkg::OP_JR, mieu_pkg::OP_JALR:
                begin
                    e.next_pc = rs;
                    e.branch_taken = 1;
                end
                mieu_pkg::OP_J, mieu_pkg::OP_JAL:
                begin
                    e.next_pc = {seq[31:28], d[132:107], 2'b00};
                    e.branch_taken = 1;
                end
                mieu_pkg::OP_BEQ:  cond = (rs == rt);
                mieu_pkg::OP_BNE:  cond = (rs != rt);
                mieu_pkg::OP_BGTZ: cond = $signed(rs) > 0;
                mieu_pkg::OP_BLEZ: cond = $signed(rs) <= 0;
                mieu_pkg::OP_BLTZ: cond = rs[31];
                mieu_pkg::OP_BGEZ: cond = !rs[31];
                default: ;
            endcase
            case (op)
                mieu_pkg::OP_ADDU, mieu_pkg::OP_ADDIU, mieu_pkg::OP_SUBU,
                mieu_pkg::OP_AND, mieu_pkg::OP_OR, mieu_pkg::OP_XOR,
                mieu_pkg::OP_ANDI, mieu_pkg::OP_ORI, mieu_pkg::OP_LUI,
                mieu_pkg::OP_SEB, mieu_pkg::OP_SLT, mieu_pkg::OP_SLTI,
                mieu_pkg::OP_SLTU, mieu_pkg::OP_SLTIU, mieu_pkg::OP_SLL,
                mieu_pkg::OP_SRL, mieu_pkg::OP_SRA, mieu_pkg::OP_MFHI,
                mieu_pkg::OP_MFLO:
                    e.writes_register = 1;
                mieu_pkg::OP_JAL, mieu_pkg::OP_JALR:
                begin
                    e.result_value = seq + 32'd4;
                    e.writes_register = 1;
                end
                default: ;
            endcase
            if (cond)
            begin
                e.next_pc = seq + (off << 2);
                e.branch_taken = 1;
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [71:0] d);
            exec_result_t a, e;
            a = d[67:0];
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, a);
                return;
            end
            e = pending.pop_front();
            if (a.result_value !== e.result_value)
            begin
                errors++;
                $display("%0t: result_value exp %h got %h", $time,
                         e.result_value, a.result_value);
            end
            if (a.writes_register !== e.writes_register)
            begin
                errors++;
                $display("%0t: writes_register exp %b got %b", $time,
                         e.writes_register, a.writes_register);
            end
            if (a.next_pc !== e.next_pc)
            begin
                errors++;
                $display("%0t: next_pc exp %h got %h", $time, e.next_pc, a.next_pc);
            end
            if (a.branch_taken !== e.branch_taken)
            begin
                errors++;
                $display("%0t: branch_taken exp %b got %b", $time,
                         e.branch_taken, a.branch_taken);
            end
            if (a.status !== e.status)
            begin
                errors++;
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;   // req_type, rs, rt, shamt, imm, offset, target, pc
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;   // result, write flag, next pc, taken, status

    exec_scoreboard sb;
    int  src_idle_pct;
    int  snk_stall_pct;
    bit  hold_sink;
    bit  stim_done;
    int  idle_cycles = 0;
    int  n_sent;

    mips_integer_execute_unit uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Sink: random stall, or a long hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 0;
        else m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_stall_pct);
    end

    // Scoreboard hooks and the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) sb.note_instr(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 5000)
            begin
                $display("watchdog: no progress at %0t", $time);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(16);
            5: return -$urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [167:0] pack_instr(logic [5:0] op, logic [31:0] rs,
            logic [31:0] rt, logic [4:0] sh, logic [15:0] imm, logic [15:0] off,
            logic [25:0] tgt, logic [31:0] pc);
        return {3'b000, pc, tgt, off, imm, sh, rt, rs, op};
    endfunction

    // Offer one item and hold it until accepted, after a random gap.
    task automatic send_instr(logic [167:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_random();
        logic [5:0] op;
        // mostly valid codes, a few unused ones that act as NOP
        op = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 36))
                                       : 6'($urandom_range(35));
        // mult/div are slow: thin them out
        if ((op == mieu_pkg::OP_MULT || op == mieu_pkg::OP_DIV) && $urandom_range(2) != 0)
            op = 6'(mieu_pkg::OP_MFLO - $urandom_range(1));
        send_instr(pack_instr(op, pick_word(),
                              ($urandom_range(9) == 0) ? 32'd0 : pick_word(),
                              5'($urandom), 16'($urandom), 16'($urandom),
                              26'($urandom), pick_word()));
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_sink = 0;
        n_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: HI/LO out of reset, overflow, mult/div, shifts, branches, jumps.
        send_instr(pack_instr(mieu_pkg::OP_MFHI, 0, 0, 0, 0, 0, 0, 32'h100));
        send_instr(pack_instr(mieu_pkg::OP_ADD, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF,
                              0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_ADDI, 32'h7FFF_FFFF, 0, 0, 16'h0001,
                              0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_SUB, 32'h8000_0000, 1, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_MULT, 32'h8000_0000, 32'h8000_0000,
                              0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_MFHI, 0, 0, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
                              0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_MFLO, 0, 0, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_DIV, 32'hFFFF_FFF9, 2, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_DIV, 5, 0, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_MFHI, 0, 0, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_BREAK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFC));
        send_instr(pack_instr(mieu_pkg::OP_SRA, 0, 32'h8000_0000, 5'd31, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_SLL, 0, 32'hFFFF_FFFF, 5'd31, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_SLTIU, 1, 0, 0, 16'h8000, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_SLTI, 32'h8000_0000, 0, 0, 16'hFFFF,
                              0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_BEQ, 3, 3, 0, 0, 16'h8000, 0, 32'h10));
        send_instr(pack_instr(mieu_pkg::OP_BNE, 3, 4, 0, 0, 16'h7FFF, 0,
                              32'hFFFF_FFF0));
        send_instr(pack_instr(mieu_pkg::OP_JAL, 0, 0, 0, 0, 0, 26'h3FF_FFFF,
                              32'hFFFF_FFFC));
        send_instr(pack_instr(mieu_pkg::OP_JALR, 32'hDEAD_BEEC, 0, 0, 0, 0, 0,
                              32'hFFFF_FFF8));
        send_instr(pack_instr(mieu_pkg::OP_SEB, 0, 32'h0000_0080, 0, 0, 0, 0, 0));
        send_instr(pack_instr(mieu_pkg::OP_LUI, 0, 0, 0, 16'hFFFF, 0, 0, 0));
        send_instr(pack_instr(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 16'hFFFF,
                              16'hFFFF, 26'h3FF_FFFF, 32'hFFFF_FFFF));

        // Random phases: none, source idle, sink stall, both light, long hold.
        for (int ph = 0; ph < 5; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 54 : ((ph == 3) ? 18 : 0);
            snk_stall_pct = (ph == 2) ? 54 : ((ph == 3) ? 18 : 0);
            if (ph == 4)
            begin
                // long sink hold-off so the unit backs up and drops tready
                hold_sink = 1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_sink = 0;
                    end
                join_none
            end
            repeat (ph == 0 ? 600 : 330) send_random();
        end
        s_axis_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d items, checked %0d results across five throttling phases.",
                 n_sent, sb.checked);
        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/mieu_pkg.sv
design/mieu_muldiv.sv
design/mieu_alu.sv
design/mips_integer_execute_unit.sv
design/mieu_checker.sv
verif/mips_integer_execute_unit_tb.sv
